// ===== rtl/core/bitmap_rank_buffer_locator_unit_assert.svh =====
// Assertion macros for the bitmap rank buffer locator.
// Included inside module bodies; depends on nothing else.
`ifndef BITMAP_RANK_BUFFER_LOCATOR_UNIT_ASSERT_SVH
`define BITMAP_RANK_BUFFER_LOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BRBL_ASSERT_IMPL(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BRBL_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/brbl_pkg.sv =====
// Shared constants, codes and helpers for the bitmap rank buffer locator.
// No dependencies.
`timescale 1ns / 1ps

package brbl_pkg;

  localparam int WORD_W   = 32;  // bitmap word
  localparam int WIDX_W   = 8;   // load word index field
  localparam int TSIZE_W  = 14;  // table size field
  localparam int KEY_W    = 13;  // key index field
  localparam int BASE_W   = 13;  // segment base field
  localparam int SEL_W    = 3;   // buffer select field
  localparam int POSN_W   = 13;  // buffer position field
  localparam int CNT_W    = 4;   // buffer count register
  localparam int BITPOS_W = 19;  // absolute bit position in the bitmap
  localparam int WADDR_W  = BITPOS_W - 5;  // absolute word index
  localparam int RANK_W   = 14;  // rank accumulator

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  function automatic logic [5:0] popcount32(input logic [WORD_W-1:0] x);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + 6'(x[i]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/bitmap_rank_buffer_locator_unit.sv =====
// Bitmap rank buffer locator: top level, one sequencer around a shared adder,
// a bitmap memory with one write port and one read port, and a word
// popcount. Depends on brbl_pkg and bitmap_rank_buffer_locator_unit_assert.svh.
`timescale 1ns / 1ps

// Holds a bitmap of BITMAP_WORDS 32-bit words (bit 31 of each word is the
// first bit) and answers lookups on it. A beat with s_tuser low loads one
// word; it yields no result. A beat with s_tuser high is a lookup: if
// table_size is under 4 or buffer_count is 1, the result is buffer 0 at
// offset key_index. Otherwise buffers are probed one by one at bit
// segment_base + b*table_size + key_index; the first set bit picks the
// buffer, and the offset is the number of set bits from that buffer's
// segment start up to the key, counted one bitmap word at a time after a
// setup step, and only when a hit has a nonempty range to count. A lookup
// is paced by the one read port of the bitmap memory and the shared adder.
// When no buffer matches, the previous result repeats with found low. A
// load may overwrite any word below BITMAP_WORDS; loads at or past it are
// dropped. Reading a word never loaded returns whatever the memory holds.
// s_tready stays low while a lookup is in flight; one finished result may
// wait in the output register while the next beat is taken. Write
// buffer_count only while the block is idle.
module bitmap_rank_buffer_locator_unit #(
  parameter int BITMAP_WORDS = 256,
  parameter int MAX_BUFFERS  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input beat.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata, from bit 0 up: word_index[7:0], word_data[39:8],
  // table_size[53:40], key_index[66:54], segment_base[79:67]
  input  logic [brbl_pkg::IN_DATA_W-1:0]    s_tdata,
  // s_tuser: operation (0 load, 1 lookup)
  input  logic                              s_tuser,
  // Result beat.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata, from bit 0 up: buffer_select[2:0], buffer_position[15:3]
  output logic [brbl_pkg::OUT_DATA_W-1:0]   m_tdata,
  // m_tuser: found
  output logic                              m_tuser,
  // Configuration: buffer_count.
  input  logic                              cfg_we,
  input  logic [brbl_pkg::CNT_W-1:0]        cfg_wdata
);
  import brbl_pkg::*;

  localparam int ADDR_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE_ADDR,
    S_PROBE_CHECK,
    S_RANK_INIT,
    S_RANK_READ,
    S_RANK_ACC,
    S_FINISH
  } state_t;

  // Field views of the input beat.
  logic [WIDX_W-1:0]  in_widx;
  logic [WORD_W-1:0]  in_wdata;
  logic [TSIZE_W-1:0] in_tsize;
  logic [KEY_W-1:0]   in_key;
  logic [BASE_W-1:0]  in_base;

  assign in_widx  = s_tdata[7:0];
  assign in_wdata = s_tdata[39:8];
  assign in_tsize = s_tdata[53:40];
  assign in_key   = s_tdata[66:54];
  assign in_base  = s_tdata[79:67];

  // Control state.
  state_t             state;
  logic [CNT_W-1:0]   buffer_count;
  logic [SEL_W-1:0]   last_buffer;
  logic [POSN_W-1:0]  last_position;

  // Lookup working registers.
  logic [CNT_W-1:0]    b_idx;
  logic [CNT_W-1:0]    n_q;
  logic [TSIZE_W-1:0]  tsize_q;
  logic [KEY_W-1:0]    key_q;
  logic [BITPOS_W-1:0] seg_q;
  logic [BITPOS_W-1:0] pos_q;
  logic [4:0]          bit_sel;
  logic [WADDR_W-1:0]  cur_word;
  logic [WADDR_W-1:0]  end_word;
  logic [4:0]          last_off;
  logic [WORD_W-1:0]   mask_q;
  logic [RANK_W-1:0]   rank_acc;

  // Pending result.
  logic [SEL_W-1:0]  res_sel;
  logic [POSN_W-1:0] res_pos;
  logic              res_found;

  // Output register.
  logic [SEL_W-1:0]  out_sel;
  logic [POSN_W-1:0] out_pos;
  logic              out_found;

  // Bitmap memory.
  logic [WORD_W-1:0] mem [BITMAP_WORDS];
  logic [WORD_W-1:0] rd_data;
  logic              rd_ok;
  logic [WADDR_W-1:0] rd_word;
  logic               wr_en;
  logic [WADDR_W-1:0] wr_word;

  // Shared adder.
  logic [BITPOS_W-1:0] add_a;
  logic [BITPOS_W-1:0] add_b;
  logic [BITPOS_W-1:0] add_sum;

  logic              in_fire;
  logic              out_load;
  logic              probe_hit;
  logic              probe_last;
  logic [CNT_W-1:0]  b_idx_inc;
  logic [CNT_W-1:0]  in_n;
  logic              in_shortcut;
  logic [WORD_W-1:0] rank_mask;
  logic [RANK_W-1:0] rank_sum;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_load = (state == S_FINISH) && (!m_tvalid || m_tready);

  assign m_tdata  = {out_pos, out_sel};
  assign m_tuser  = out_found;

  // Clamp the buffer count to what the block supports.
  assign in_n = (32'(buffer_count) > MAX_BUFFERS) ? CNT_W'(MAX_BUFFERS) : buffer_count;
  assign in_shortcut = (in_tsize < TSIZE_W'(4)) || (buffer_count == CNT_W'(1));

  // Shared adder operand select: probe position, next segment start, or
  // last counted bit (probe position minus one).
  always_comb begin
    add_a = seg_q;
    add_b = BITPOS_W'(key_q);
    case (state)
      S_PROBE_ADDR: begin
        add_a = seg_q;
        add_b = BITPOS_W'(key_q);
      end
      S_PROBE_CHECK: begin
        add_a = seg_q;
        add_b = BITPOS_W'(tsize_q);
      end
      S_RANK_INIT: begin
        add_a = pos_q;
        add_b = '1;
      end
      default: begin
        add_a = seg_q;
        add_b = BITPOS_W'(key_q);
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  // Memory read address: the probed word, else the word under count.
  assign rd_word = (state == S_PROBE_ADDR) ? add_sum[BITPOS_W-1:5] : cur_word;

  assign wr_word = WADDR_W'(in_widx);
  assign wr_en   = in_fire && (op_t'(s_tuser) == OP_LOAD)
                   && (wr_word < WADDR_W'(BITMAP_WORDS));

  // Bit 31 is the first bit, so bit offset k sits at index 31 - k = ~k.
  assign probe_hit  = rd_ok && rd_data[~bit_sel];
  assign b_idx_inc  = b_idx + CNT_W'(1);
  assign probe_last = (b_idx_inc == n_q);

  // Mask of the counted bits in the current word.
  always_comb begin
    rank_mask = '1;
    if (cur_word == seg_q[BITPOS_W-1:5]) begin
      rank_mask = rank_mask & ({WORD_W{1'b1}} >> seg_q[4:0]);
    end
    if (cur_word == end_word) begin
      rank_mask = rank_mask & ({WORD_W{1'b1}} << (~last_off));
    end
  end

  assign rank_sum = rank_acc + RANK_W'(popcount32(rd_data & mask_q & {WORD_W{rd_ok}}));

  // Bitmap memory: one write port from loads, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_word[ADDR_W-1:0]] <= in_wdata;
    end
    rd_data <= mem[rd_word[ADDR_W-1:0]];
    rd_ok   <= (rd_word < WADDR_W'(BITMAP_WORDS));
  end

  // Sequencer, configuration register and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      buffer_count  <= CNT_W'(1);
      last_buffer   <= '0;
      last_position <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        buffer_count <= cfg_wdata;
      end

      // Drop the result once taken, unless a new one replaces it below.
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire && (op_t'(s_tuser) == OP_LOOKUP)) begin
            tsize_q <= in_tsize;
            key_q   <= in_key;
            seg_q   <= BITPOS_W'(in_base);
            n_q     <= in_n;
            b_idx   <= '0;
            if (in_shortcut) begin
              res_sel   <= '0;
              res_pos   <= in_key;
              res_found <= 1'b1;
              state     <= S_FINISH;
            end else if (in_n == '0) begin
              // No buffer to try: repeat the previous answer.
              res_sel   <= last_buffer;
              res_pos   <= last_position;
              res_found <= 1'b0;
              state     <= S_FINISH;
            end else begin
              state <= S_PROBE_ADDR;
            end
          end
        end

        S_PROBE_ADDR: begin
          // Read the word holding the probed bit.
          pos_q   <= add_sum;
          bit_sel <= add_sum[4:0];
          state   <= S_PROBE_CHECK;
        end

        S_PROBE_CHECK: begin
          if (probe_hit) begin
            res_sel   <= b_idx[SEL_W-1:0];
            res_found <= 1'b1;
            if (key_q == '0) begin
              res_pos <= '0;
              state   <= S_FINISH;
            end else begin
              state <= S_RANK_INIT;
            end
          end else if (probe_last) begin
            res_sel   <= last_buffer;
            res_pos   <= last_position;
            res_found <= 1'b0;
            state     <= S_FINISH;
          end else begin
            // Advance to the next buffer's segment.
            b_idx <= b_idx_inc;
            seg_q <= add_sum;
            state <= S_PROBE_ADDR;
          end
        end

        S_RANK_INIT: begin
          end_word <= add_sum[BITPOS_W-1:5];
          last_off <= add_sum[4:0];
          cur_word <= seg_q[BITPOS_W-1:5];
          rank_acc <= '0;
          state    <= S_RANK_READ;
        end

        S_RANK_READ: begin
          mask_q <= rank_mask;
          state  <= S_RANK_ACC;
        end

        S_RANK_ACC: begin
          rank_acc <= rank_sum;
          if (cur_word == end_word) begin
            res_pos <= rank_sum[POSN_W-1:0];
            state   <= S_FINISH;
          end else begin
            cur_word <= cur_word + WADDR_W'(1);
            state    <= S_RANK_READ;
          end
        end

        S_FINISH: begin
          // Hold until the output register is free.
          if (out_load) begin
            out_sel       <= res_sel;
            out_pos       <= res_pos;
            out_found     <= res_found;
            m_tvalid      <= 1'b1;
            last_buffer   <= res_sel;
            last_position <= res_pos;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "bitmap_rank_buffer_locator_unit_assert.svh"

  // A count never exceeds the key it stops at.
  `BRBL_ASSERT_IMPL(a_rank_bound, clk, rst, state == S_RANK_ACC,
                    rank_acc <= RANK_W'(key_q), "rank count ran past key")
  // Probing stays within the clamped buffer count.
  `BRBL_ASSERT_IMPL(a_probe_range, clk, rst, state == S_PROBE_ADDR,
                    b_idx < n_q, "probe beyond buffer count")
  // A miss result is always the previous answer.
  `BRBL_ASSERT_IMPL(a_miss_repeats, clk, rst, (state == S_FINISH) && !res_found,
                    (res_sel == last_buffer) && (res_pos == last_position),
                    "miss does not repeat last result")
  // A missed probe moves the segment start forward by one table size.
  `BRBL_ASSERT_NEXT(a_seg_step, clk, rst,
                    (state == S_PROBE_CHECK) && !probe_hit && !probe_last,
                    seg_q == ($past(seg_q) + BITPOS_W'($past(tsize_q))),
                    "segment step wrong")

endmodule
